// ----- src/streaming_kth_largest_assert.svh -----
// Assertion macros shared by the checker of the k-th largest finder.
`ifndef STREAMING_KTH_LARGEST_ASSERT_SVH
`define STREAMING_KTH_LARGEST_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define SKL_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define SKL_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- src/skl_pkg.sv -----
// Shared constants and types for the streaming k-th largest finder.
`default_nettype none

package skl_pkg;

    localparam int VALUE_W      = 32;
    localparam int RANK_W       = 9;
    localparam int MAX_RANK_DEF = 256;

    // Per-cycle operation broadcast along the cell chain
    typedef enum logic [1:0] {
        MODE_HOLD    = 2'd0,
        MODE_INSERT  = 2'd1,
        MODE_REPLACE = 2'd2,
        MODE_SHIFT   = 2'd3
    } cell_mode_t;

endpackage

`default_nettype wire

// ----- src/streaming_kth_largest.sv -----
// Top level of the streaming k-th largest finder.
//
// Input channel (in_valid / in_stall) carries sample_value and final_item;
// a beat is taken when in_valid is high and in_stall is low. Output channel
// (out_valid / out_stall) carries kth_largest and enough_seen, one beat per
// data set, produced by the beat that has final_item set.
// Configuration: rank_k is written through cfg_valid / cfg_ready (always
// ready); write it only while no beat is in flight. A lowered rank takes
// effect on the next sample beat, even with a data set left open.
// Throughput: one input beat per cycle while in_stall is low. Every cell of the sorted chain
// compares its value with the new sample in the same cycle and holds, takes the sample or shifts one
// place, so the chain length does not slow the stream.
// Latency: the result beat is valid the cycle after the final beat is taken.
// After rank_k is lowered below the count still kept, the next input beat
// stalls until the count is down to k, while the chain drops its smallest
// value once a cycle as long as that beat waits. A final beat also stalls
// while a result waits and out_stall is high; other beats keep flowing.
// Reset: fill count goes to zero and rank_reg to 1; the cell contents need no
// clearing pass, since only cells below the fill count are ever used.
// A held result stays unchanged while out_stall is high.
`default_nettype none

module streaming_kth_largest #(
    parameter int MAX_RANK = skl_pkg::MAX_RANK_DEF
) (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire logic                                cfg_valid,
    output logic                                     cfg_ready,
    input  wire logic [skl_pkg::RANK_W-1:0]          rank_k,
    input  wire logic                                in_valid,
    output logic                                     in_stall,
    input  wire logic signed [skl_pkg::VALUE_W-1:0]  sample_value,
    input  wire logic                                final_item,
    output logic                                     out_valid,
    input  wire logic                                out_stall,
    output logic signed [skl_pkg::VALUE_W-1:0]       kth_largest,
    output logic                                     enough_seen
);

    localparam int CNT_W = $clog2(MAX_RANK + 1);

    logic [skl_pkg::RANK_W-1:0]          rank_reg;
    logic [CNT_W-1:0]                    count_reg;
    logic [CNT_W-1:0]                    count_next;
    logic [CNT_W-1:0]                    count_inc;
    logic [CNT_W-1:0]                    k_eff;
    logic                                trimming;
    logic                                full;
    logic                                accept;
    logic                                enough;
    skl_pkg::cell_mode_t                 mode;
    logic signed [skl_pkg::VALUE_W-1:0]  head_next;
    logic                                out_valid_reg;
    logic                                out_valid_next;
    logic signed [skl_pkg::VALUE_W-1:0]  kth_reg;
    logic                                enough_reg;

    assign cfg_ready = 1'b1;

    // Clamp the rank to the range the chain can hold
    always_comb
    begin
        if (rank_reg == '0)
            k_eff = CNT_W'(1);
        else if (32'(rank_reg) > 32'(MAX_RANK))
            k_eff = CNT_W'(MAX_RANK);
        else
            k_eff = CNT_W'(rank_reg);
    end

    assign trimming  = count_reg > k_eff;
    assign full      = count_reg == k_eff;
    assign count_inc = count_reg + CNT_W'(1);
    assign in_stall  = trimming || (out_valid_reg && out_stall && final_item);
    assign accept    = in_valid && !in_stall;
    assign enough    = full || (count_inc == k_eff);

    // Choose the chain operation and the next fill count
    always_comb
    begin
        mode       = skl_pkg::MODE_HOLD;
        count_next = count_reg;
        if (trimming)
        begin
            // Drop the smallest only once a beat is waiting
            if (in_valid)
            begin
                mode       = skl_pkg::MODE_SHIFT;
                count_next = count_reg - CNT_W'(1);
            end
        end
        else if (accept)
        begin
            mode = full ? skl_pkg::MODE_REPLACE : skl_pkg::MODE_INSERT;
            if (final_item)
                count_next = '0;
            else if (!full)
                count_next = count_inc;
        end
    end

    skl_chain #(
        .MAX_RANK (MAX_RANK),
        .CNT_W    (CNT_W)
    ) u_chain (
        .clk       (clk),
        .mode      (mode),
        .count     (count_reg),
        .sample    (sample_value),
        .head_next (head_next)
    );

    // Raise the result on a final beat, drop it once taken
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (accept && final_item)
            out_valid_next = 1'b1;
        else if (out_valid_reg && !out_stall)
            out_valid_next = 1'b0;
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rank_reg      <= skl_pkg::RANK_W'(1);
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
                rank_reg <= rank_k;
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Capture the result payload
    always_ff @(posedge clk)
    begin
        if (accept && final_item)
        begin
            kth_reg    <= enough ? head_next : '0;
            enough_reg <= enough;
        end
    end

    assign out_valid   = out_valid_reg;
    assign kth_largest = kth_reg;
    assign enough_seen = enough_reg;

endmodule

`default_nettype wire

// ----- src/skl_cell.sv -----
// One cell of the sorted chain: holds a single kept value.
`default_nettype none

module skl_cell #(
    parameter int CNT_W = 9,
    parameter int INDEX = 0
) (
    input  wire logic                                    clk,
    input  wire skl_pkg::cell_mode_t                     mode,
    input  wire logic [CNT_W-1:0]                        count,
    input  wire logic signed [skl_pkg::VALUE_W-1:0]      sample,
    input  wire logic signed [skl_pkg::VALUE_W-1:0]      lo_value,
    input  wire logic                                    lo_le,
    input  wire logic signed [skl_pkg::VALUE_W-1:0]      hi_value,
    input  wire logic                                    hi_le,
    output logic signed [skl_pkg::VALUE_W-1:0]           value,
    output logic                                         le,
    output logic signed [skl_pkg::VALUE_W-1:0]           value_next
);

    logic signed [skl_pkg::VALUE_W-1:0] value_reg;
    logic                               cell_valid;

    // Cell is occupied when its position lies below the fill count
    assign cell_valid = CNT_W'(INDEX) < count;
    assign le         = cell_valid && (value_reg <= sample);
    assign value      = value_reg;

    // Pick the next value from self, the new sample or a neighbour
    always_comb
    begin
        value_next = value_reg;
        case (mode)
            skl_pkg::MODE_INSERT:
            begin
                if (le)
                    value_next = value_reg;
                else if (lo_le)
                    value_next = sample;
                else
                    value_next = lo_value;
            end
            skl_pkg::MODE_REPLACE:
            begin
                if (hi_le)
                    value_next = hi_value;
                else if (le)
                    value_next = sample;
                else
                    value_next = value_reg;
            end
            skl_pkg::MODE_SHIFT:
            begin
                value_next = hi_value;
            end
            default:
            begin
                value_next = value_reg;
            end
        endcase
    end

    // Hold the value
    always_ff @(posedge clk)
    begin
        value_reg <= value_next;
    end

endmodule

`default_nettype wire

// ----- src/skl_chain.sv -----
// Row of sorted cells, ascending from the head (smallest kept value).
`default_nettype none

module skl_chain #(
    parameter int MAX_RANK = skl_pkg::MAX_RANK_DEF,
    parameter int CNT_W    = $clog2(MAX_RANK + 1)
) (
    input  wire logic                                clk,
    input  wire skl_pkg::cell_mode_t                 mode,
    input  wire logic [CNT_W-1:0]                    count,
    input  wire logic signed [skl_pkg::VALUE_W-1:0]  sample,
    output logic signed [skl_pkg::VALUE_W-1:0]       head_next
);

    logic signed [skl_pkg::VALUE_W-1:0] cell_value [MAX_RANK];
    logic                               cell_le    [MAX_RANK];

    // Wire each cell to its lower and upper neighbour
    for (genvar i = 0; i < MAX_RANK; i++)
    begin : g_cell
        logic signed [skl_pkg::VALUE_W-1:0] lo_value;
        logic                               lo_le;
        logic signed [skl_pkg::VALUE_W-1:0] hi_value;
        logic                               hi_le;

        if (i == 0)
        begin : g_head
            assign lo_value = sample;
            assign lo_le    = 1'b1;
        end
        else
        begin : g_body_lo
            assign lo_value = cell_value[i-1];
            assign lo_le    = cell_le[i-1];
        end

        if (i == MAX_RANK - 1)
        begin : g_tail
            assign hi_value = cell_value[i];
            assign hi_le    = 1'b0;
        end
        else
        begin : g_body_hi
            assign hi_value = cell_value[i+1];
            assign hi_le    = cell_le[i+1];
        end

        if (i == 0)
        begin : g_head_out
            skl_cell #(
                .CNT_W (CNT_W),
                .INDEX (i)
            ) u_cell (
                .clk        (clk),
                .mode       (mode),
                .count      (count),
                .sample     (sample),
                .lo_value   (lo_value),
                .lo_le      (lo_le),
                .hi_value   (hi_value),
                .hi_le      (hi_le),
                .value      (cell_value[i]),
                .le         (cell_le[i]),
                .value_next (head_next)
            );
        end
        else
        begin : g_body_out
            skl_cell #(
                .CNT_W (CNT_W),
                .INDEX (i)
            ) u_cell (
                .clk        (clk),
                .mode       (mode),
                .count      (count),
                .sample     (sample),
                .lo_value   (lo_value),
                .lo_le      (lo_le),
                .hi_value   (hi_value),
                .hi_le      (hi_le),
                .value      (cell_value[i]),
                .le         (cell_le[i]),
                .value_next ()
            );
        end
    end

endmodule

`default_nettype wire

// ----- src/skl_checker.sv -----
// Port-level checker for the streaming k-th largest finder, bound to the top.
`default_nettype none

`include "streaming_kth_largest_assert.svh"

module skl_checker (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire logic                                cfg_valid,
    input  wire logic                                cfg_ready,
    input  wire logic [skl_pkg::RANK_W-1:0]          rank_k,
    input  wire logic                                in_valid,
    input  wire logic                                in_stall,
    input  wire logic signed [skl_pkg::VALUE_W-1:0]  sample_value,
    input  wire logic                                final_item,
    input  wire logic                                out_valid,
    input  wire logic                                out_stall,
    input  wire logic signed [skl_pkg::VALUE_W-1:0]  kth_largest,
    input  wire logic                                enough_seen
);

    // Held result beat keeps its payload
    `SKL_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && out_stall, out_valid && $stable(kth_largest) && $stable(enough_seen), "result changed while stalled")

    // Short data set reports zero
    `SKL_ASSERT_NOW(a_short_zero, clk, rst_n, out_valid && !enough_seen, kth_largest == 0, "short set result not zero")

    // Blocked output blocks a final beat
    `SKL_ASSERT_NOW(a_backpressure, clk, rst_n, out_valid && out_stall && in_valid && final_item, in_stall, "final beat taken while result blocked")

    // Final beat yields a result next cycle
    `SKL_ASSERT_NEXT(a_final_result, clk, rst_n, in_valid && !in_stall && final_item, out_valid, "no result after final beat")

    // Non-final beat with no result waiting yields no result
    `SKL_ASSERT_NEXT(a_no_spurious, clk, rst_n, in_valid && !in_stall && !final_item && !out_valid, !out_valid, "result without final beat")

endmodule

bind streaming_kth_largest skl_checker u_checker (.*);

`default_nettype wire

// ----- tb/tb_streaming_kth_largest.sv -----
// Self-checking testbench for the streaming k-th largest finder, with its own sorted-set model.
`timescale 1ns / 1ps

module tb_streaming_kth_largest;

    localparam int CLK_PERIOD    = 20;
    localparam int TOP_RANK      = skl_pkg::MAX_RANK_DEF;
    localparam int RANK_CODE_MAX = (1 << skl_pkg::RANK_W) - 1;
    localparam int IDLE_LIMIT    = 2000;
    localparam int SETTLE_CYCLES = 4;
    localparam int DRAIN_CYCLES  = 10;
    localparam int TARGET_VALUES = 800;
    localparam int REPORT_MAX    = 10;

    typedef logic signed [skl_pkg::VALUE_W-1:0] sample_t;

    localparam sample_t VALUE_MIN = {1'b1, {(skl_pkg::VALUE_W-1){1'b0}}};
    localparam sample_t VALUE_MAX = {1'b0, {(skl_pkg::VALUE_W-1){1'b1}}};

    typedef struct {
        sample_t value;
        bit      is_last;
        bit      drain_first;   // hold this beat back until every result is in
    } sample_beat_t;

    typedef struct {
        sample_t kth;
        logic    enough;
    } rank_result_t;

    logic                         clk          = 1'b0;
    logic                         rst_n        = 1'b0;
    logic                         cfg_valid    = 1'b0;
    logic                         cfg_ready;
    logic [skl_pkg::RANK_W-1:0]   rank_k       = skl_pkg::RANK_W'(1);
    logic                         in_valid     = 1'b0;
    logic                         in_stall;
    sample_t                      sample_value = '0;
    logic                         final_item   = 1'b0;
    logic                         out_valid;
    logic                         out_stall    = 1'b0;
    sample_t                      kth_largest;
    logic                         enough_seen;

    // Model state: kept values in ascending order and the current rank code
    sample_t             kept_set[$];
    int unsigned         rank_setting = 1;
    rank_result_t        expected_kth_q[$];
    sample_beat_t        sample_backlog[$];

    int                  sets_closed   = 0;
    int                  results_taken = 0;
    int                  send_wait     = 0;
    int                  stall_left    = 0;
    int                  quiet_cycles  = 0;
    int                  faults        = 0;
    int                  values_queued = 0;
    int                  values_taken  = 0;
    int                  rank_writes   = 0;
    bit                  sender_idles   = 1'b1;
    bit                  receiver_idles = 1'b1;

    streaming_kth_largest #(.MAX_RANK(TOP_RANK)) uut (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .rank_k       (rank_k),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .sample_value (sample_value),
        .final_item   (final_item),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .kth_largest  (kth_largest),
        .enough_seen  (enough_seen)
    );

    always #(CLK_PERIOD / 2) clk = ~clk;

    // Add one value to the kept set, shed the smallest down to k, close the set on the last beat
    function automatic void absorb_sample(input sample_t v, input logic last);
        int unsigned  k;
        int           pos;
        rank_result_t res;
        k = (rank_setting == 0) ? 1 : ((rank_setting > TOP_RANK) ? TOP_RANK : rank_setting);
        pos = 0;
        while (pos < kept_set.size() && kept_set[pos] <= v)
            pos++;
        kept_set.insert(pos, v);
        while (kept_set.size() > k)
            void'(kept_set.pop_front());
        if (last)
        begin
            if (kept_set.size() >= k)
            begin
                res.kth    = kept_set[0];
                res.enough = 1'b1;
            end
            else
            begin
                res.kth    = '0;
                res.enough = 1'b0;
            end
            expected_kth_q.push_back(res);
            kept_set.delete();
        end
    endfunction

    function automatic void report_fault(input string msg);
        faults++;
        if (faults <= REPORT_MAX)
            $display("[%0t] %s", $realtime, msg);
    endfunction

    function automatic void queue_sample(input sample_t v, input bit last, input bit drain);
        sample_beat_t b;
        b.value       = v;
        b.is_last     = last;
        b.drain_first = drain;
        sample_backlog.push_back(b);
        values_queued++;
    endfunction

    // Mix extremes, a narrow band that forces ties, and full-width words
    function automatic sample_t pick_value();
        case ($urandom_range(0, 9))
            0:       return VALUE_MIN;
            1:       return VALUE_MAX;
            2, 3:    return sample_t'($urandom_range(0, 16)) - sample_t'(8);
            default: return sample_t'($urandom);
        endcase
    endfunction

    // Wait until every beat is taken and every result is in, then let the chain settle
    task automatic wait_idle();
        while (sample_backlog.size() != 0 || in_valid || expected_kth_q.size() != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic change_rank(input int unsigned value);
        wait_idle();
        @(posedge clk);
        cfg_valid <= 1'b1;
        rank_k    <= skl_pkg::RANK_W'(value);
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        @(negedge clk);
    endtask

    // Sample side: present beats from the backlog, now and then idling between them
    always @(posedge clk or negedge rst_n)
    begin : drive_samples
        sample_beat_t nxt;
        int           owed;
        bit           slot_free;
        if (!rst_n)
        begin
            in_valid     <= 1'b0;
            sample_value <= '0;
            final_item   <= 1'b0;
            send_wait     = 0;
        end
        else
        begin
            slot_free = !in_valid || !in_stall;
            owed = sets_closed - results_taken
                 + ((in_valid && !in_stall && final_item) ? 1 : 0)
                 - ((out_valid && !out_stall) ? 1 : 0);
            if (in_valid && !in_stall)
                send_wait = sender_idles ? $urandom_range(0, 6) : 0;
            else if (!in_valid && send_wait > 0)
                send_wait--;
            if (slot_free && send_wait == 0 && sample_backlog.size() != 0
                && !(sample_backlog[0].drain_first && owed != 0))
            begin
                nxt = sample_backlog.pop_front();
                in_valid     <= 1'b1;
                sample_value <= nxt.value;
                final_item   <= nxt.is_last;
            end
            else if (slot_free)
                in_valid <= 1'b0;
        end
    end

    // Result side: at times stall after a beat, and now and then before one arrives
    always @(posedge clk or negedge rst_n)
    begin : drive_stall
        if (!rst_n)
        begin
            out_stall <= 1'b0;
            stall_left = 0;
        end
        else
        begin
            if (out_valid && !out_stall)
                stall_left = receiver_idles ? $urandom_range(0, 6) : 0;
            else if (stall_left > 0)
                stall_left--;
            else if (receiver_idles && $urandom_range(0, 7) == 0)
                stall_left = $urandom_range(1, 6);
            out_stall <= (stall_left > 0);
        end
    end

    // Track rank writes and sample beats, check each result beat against the oldest expectation
    always @(posedge clk)
    begin : watch_ports
        rank_result_t want;
        if (rst_n)
        begin
            if (cfg_valid && cfg_ready)
            begin
                rank_setting = rank_k;
                rank_writes++;
            end
            if (in_valid && !in_stall)
            begin
                absorb_sample(sample_value, final_item);
                values_taken++;
                if (final_item)
                    sets_closed <= sets_closed + 1;
            end
            if (out_valid && !out_stall)
            begin
                results_taken <= results_taken + 1;
                if (expected_kth_q.size() == 0)
                    report_fault($sformatf("result with none pending: kth=%0d enough=%0b",
                                           kth_largest, enough_seen));
                else
                begin
                    want = expected_kth_q.pop_front();
                    if (kth_largest !== want.kth || enough_seen !== want.enough)
                        report_fault($sformatf(
                            "result %0d: expected kth=%0d enough=%0b, got kth=%0d enough=%0b",
                            results_taken, want.kth, want.enough, kth_largest, enough_seen));
                end
            end
        end
    end

    // Abort when nothing moves on any channel for too long
    always @(posedge clk)
    begin : watchdog
        if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)
            || (cfg_valid && cfg_ready))
            quiet_cycles <= 0;
        else if (quiet_cycles + 1 >= IDLE_LIMIT)
        begin
            $display("Timeout: no beat for %0d cycles", IDLE_LIMIT);
            $display("Some tests failed");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    initial
    begin : stimulus
        int unsigned k;
        int unsigned eff;
        int          n_sets;
        int          len;
        bit          big_done;
        big_done = 1'b0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Directed: reset rank of one, extremes, a paused beat
        queue_sample(VALUE_MIN, 1, 0);
        queue_sample(VALUE_MAX, 0, 1);
        queue_sample(VALUE_MIN, 1, 0);
        // Ties in the kept set, then a set too short for the rank
        change_rank(3);
        queue_sample(-1, 0, 0);
        queue_sample(5, 0, 0);
        queue_sample(5, 0, 0);
        queue_sample(0, 1, 0);
        queue_sample(7, 0, 0);
        queue_sample(8, 1, 0);
        // Rank code zero behaves as one
        change_rank(0);
        queue_sample(3, 0, 0);
        queue_sample(-4, 1, 0);
        // Top rank code clips to the store depth
        change_rank(RANK_CODE_MAX);
        queue_sample(1, 0, 0);
        queue_sample(2, 1, 0);
        // Lower the rank with a set still open
        change_rank(4);
        queue_sample(10, 0, 0);
        queue_sample(20, 0, 0);
        queue_sample(30, 0, 0);
        queue_sample(40, 0, 0);
        queue_sample(50, 0, 0);
        change_rank(2);
        queue_sample(5, 1, 0);

        // Random phases: new rank, a few sets, sometimes a set left open
        while (values_queued < TARGET_VALUES)
        begin
            if (!big_done && values_queued > TARGET_VALUES / 3)
            begin
                // Fill the store exactly, then leave a long set open for the next rank to cut
                big_done = 1'b1;
                change_rank(TOP_RANK);
                for (int i = 0; i < TOP_RANK; i++)
                    queue_sample(pick_value(), i == TOP_RANK - 1, 0);
                repeat (40) queue_sample(pick_value(), 0, 0);
                continue;
            end
            case ($urandom_range(0, 9))
                0:       k = $urandom_range(0, 1) ? 0 : $urandom_range(TOP_RANK + 1, RANK_CODE_MAX);
                1, 2:    k = $urandom_range(9, 40);
                default: k = $urandom_range(1, 8);
            endcase
            eff = (k == 0) ? 1 : ((k > TOP_RANK) ? TOP_RANK : k);
            change_rank(k);
            sender_idles   = $urandom_range(0, 3) != 0;
            receiver_idles = $urandom_range(0, 3) != 0;
            n_sets = $urandom_range(1, 6);
            for (int s = 0; s < n_sets; s++)
            begin
                len = (eff > 40) ? $urandom_range(1, 8) : $urandom_range(1, 2 * eff + 2);
                for (int i = 0; i < len; i++)
                    queue_sample(pick_value(), i == len - 1, i == 0 && $urandom_range(0, 7) == 0);
            end
            if ($urandom_range(0, 5) == 0)
            begin
                len = (eff > 40) ? $urandom_range(1, 8) : $urandom_range(1, 2 * eff + 2);
                repeat (len) queue_sample(pick_value(), 0, 0);
            end
        end

        // Drain and give the verdict
        while (sample_backlog.size() != 0 || in_valid)
            @(negedge clk);
        while (expected_kth_q.size() != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (expected_kth_q.size() != 0)
            report_fault($sformatf("%0d results never arrived", expected_kth_q.size()));

        $display("Streamed %0d values, checked %0d k-th largest results, %0d rank writes",
                 values_taken, results_taken, rank_writes);
        $display("Ranks spanned codes 0 to %0d incl. a full store, short sets, mid-set cuts",
                 RANK_CODE_MAX);
        if (faults == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule
